>>> rtl/stable_four_class_priority_queue_top_defines.svh
// Assertion macros used by the checker file of the priority queue.
`ifndef STABLE_FOUR_CLASS_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_FOUR_CLASS_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SFCPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SFCPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sfcpq_pkg.sv
// Package with the types, codes and constants of the stable four-class priority queue.
package sfcpq_pkg;

	localparam int DEPTH_DEFAULT = 8;
	localparam logic [6:0] AGE_THRESHOLD_RESET = 7'd60;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_PEEK   = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam logic [2:0] OPC_NOP       = 3'd0;
	localparam logic [2:0] OPC_INSERT    = 3'd1;
	localparam logic [2:0] OPC_REMOVE    = 3'd2;
	localparam logic [2:0] OPC_PEEK      = 3'd3;
	localparam logic [2:0] OPC_REJ_FULL  = 3'd4;
	localparam logic [2:0] OPC_REJ_EMPTY = 3'd5;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] ident;
		logic [6:0]  age;
		logic        disabled;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_ident;
		logic [6:0]  out_age;
		logic        out_disabled;
		logic [2:0]  out_class;
		logic [3:0]  occupancy;
	} rsp_t;

	// The class is stored as class minus one.
	typedef struct packed {
		logic [15:0] ident;
		logic [6:0]  age;
		logic        disabled;
		logic [1:0]  cls;
	} entry_t;

	typedef struct packed {
		logic       load;
		logic [2:0] op;
		logic       cfg_we;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stat_t;

endpackage

>>> rtl/stable_four_class_priority_queue_top.sv
// Top level of the stable four-class priority queue.
//
//   Channel  Signals                        Carries
//   req      req_valid, req_ready, req      one action beat: insert, remove or peek
//   rsp      rsp_valid, rsp_ready, rsp      one result beat per request beat
//   cfg      cfg_valid, cfg_ready, cfg_data age threshold write, always ready
//
// For a request beat the sorted cells compare and shift in parallel and the result is
// registered at the same edge, and one beat is accepted per cycle while not stalled.
// A new request is taken while the held result is being taken by the consumer.
// When the result register is full and rsp_ready is low, req_ready is low.
// Reset empties the queue and loads the threshold with 60; no clearing pass is needed.
module stable_four_class_priority_queue_top #(
	parameter int DEPTH = sfcpq_pkg::DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  sfcpq_pkg::req_t  req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output sfcpq_pkg::rsp_t  rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [6:0]       cfg_data
);

	sfcpq_pkg::cmd_t  cmd;
	sfcpq_pkg::stat_t stat;

	sfcpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.action    (req.action),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sfcpq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.rsp      (rsp)
	);

endmodule

>>> rtl/sfcpq_ctrl.sv
// Controller of the priority queue: result register state and operation decode.
module sfcpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        action,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  sfcpq_pkg::stat_t  stat,
	output sfcpq_pkg::cmd_t   cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_HOLD = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;
	logic [2:0] op_dec;

	assign req_ready = (state_q == S_IDLE) || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = (state_q == S_HOLD);
	assign cfg_ready = 1'b1;

	always_comb begin
		unique case (action)
			sfcpq_pkg::ACT_INSERT: begin
				op_dec = stat.full ? sfcpq_pkg::OPC_REJ_FULL : sfcpq_pkg::OPC_INSERT;
			end
			sfcpq_pkg::ACT_REMOVE: begin
				op_dec = stat.empty ? sfcpq_pkg::OPC_REJ_EMPTY : sfcpq_pkg::OPC_REMOVE;
			end
			sfcpq_pkg::ACT_PEEK: begin
				op_dec = stat.empty ? sfcpq_pkg::OPC_REJ_EMPTY : sfcpq_pkg::OPC_PEEK;
			end
			default: begin
				op_dec = sfcpq_pkg::OPC_NOP;
			end
		endcase
	end

	always_comb begin
		cmd.load   = accept;
		cmd.op     = accept ? op_dec : sfcpq_pkg::OPC_NOP;
		cmd.cfg_we = cfg_valid;
	end

	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				state_d = accept ? S_HOLD : S_IDLE;
			end
			S_HOLD: begin
				if (accept) begin
					state_d = S_HOLD;
				end else if (rsp_ready) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_HOLD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/sfcpq_datapath.sv
// Datapath of the priority queue: sorted entry cells, count, threshold and result register.
module sfcpq_datapath #(
	parameter int DEPTH = sfcpq_pkg::DEPTH_DEFAULT,
	localparam int CntW = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sfcpq_pkg::req_t   req,
	input  logic [6:0]        cfg_data,
	input  sfcpq_pkg::cmd_t   cmd,
	output sfcpq_pkg::stat_t  stat,
	output sfcpq_pkg::rsp_t   rsp
);

	sfcpq_pkg::entry_t cell_q [DEPTH];
	logic [CntW-1:0]   count_q;
	logic [CntW-1:0]   count_d;
	logic [6:0]        thresh_q;
	sfcpq_pkg::rsp_t   rsp_q;
	sfcpq_pkg::rsp_t   rsp_d;
	sfcpq_pkg::entry_t new_e;
	logic [DEPTH-1:0]  le;
	logic [CntW+3:0]   occ_ext;
	logic              elder;

	assign elder          = req.age > thresh_q;
	assign new_e.ident    = req.ident;
	assign new_e.age      = req.age;
	assign new_e.disabled = req.disabled;
	assign new_e.cls      = {~req.disabled, ~elder};

	// A held entry stays in place when its class is the same or better.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		sfcpq_pkg::entry_t prev_e;
		sfcpq_pkg::entry_t succ_e;
		logic              prev_le;

		assign le[g] = (CntW'(g) < count_q) && (cell_q[g].cls <= new_e.cls);

		if (g == 0) begin : g_first
			assign prev_e  = new_e;
			assign prev_le = 1'b1;
		end else begin : g_rest
			assign prev_e  = cell_q[g-1];
			assign prev_le = le[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign succ_e = cell_q[g];
		end else begin : g_inner
			assign succ_e = cell_q[g+1];
		end

		always_ff @(posedge clk) begin
			unique case (cmd.op)
				sfcpq_pkg::OPC_INSERT: begin
					if (!le[g]) begin
						cell_q[g] <= prev_le ? new_e : prev_e;
					end
				end
				sfcpq_pkg::OPC_REMOVE: begin
					cell_q[g] <= succ_e;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (cmd.op)
			sfcpq_pkg::OPC_INSERT: count_d = count_q + CntW'(1);
			sfcpq_pkg::OPC_REMOVE: count_d = count_q - CntW'(1);
			default:               count_d = count_q;
		endcase
	end

	assign occ_ext = (CntW + 4)'(count_d);

	always_comb begin
		rsp_d              = '0;
		rsp_d.status       = sfcpq_pkg::STATUS_OK;
		rsp_d.occupancy    = occ_ext[3:0];
		unique case (cmd.op) inside
			sfcpq_pkg::OPC_REMOVE, sfcpq_pkg::OPC_PEEK: begin
				rsp_d.out_ident    = cell_q[0].ident;
				rsp_d.out_age      = cell_q[0].age;
				rsp_d.out_disabled = cell_q[0].disabled;
				rsp_d.out_class    = {1'b0, cell_q[0].cls} + 3'd1;
			end
			sfcpq_pkg::OPC_REJ_FULL: begin
				rsp_d.status = sfcpq_pkg::STATUS_FULL;
			end
			sfcpq_pkg::OPC_REJ_EMPTY: begin
				rsp_d.status = sfcpq_pkg::STATUS_EMPTY;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			thresh_q <= sfcpq_pkg::AGE_THRESHOLD_RESET;
		end else begin
			count_q <= count_d;
			if (cmd.cfg_we) begin
				thresh_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q <= rsp_d;
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CntW'(DEPTH));
	assign rsp        = rsp_q;

endmodule

>>> rtl/sfcpq_checker.sv
// Port checker of the priority queue and its bind to the top level.
`include "stable_four_class_priority_queue_top_defines.svh"

module sfcpq_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input sfcpq_pkg::rsp_t rsp
);

	`SFCPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "Result beat changed while stalled.")

	`SFCPQ_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready, rsp_valid, "Accepted request beat gave no result beat.")

	`SFCPQ_ASSERT_NOW(a_ready_free, !rsp_valid, req_ready, "Request not taken while the result register is free.")

	`SFCPQ_ASSERT_NOW(a_empty_fields, rsp_valid && (rsp.status == sfcpq_pkg::STATUS_EMPTY), (rsp.occupancy == 4'd0) && (rsp.out_class == 3'd0), "Empty result beat shows a head or a count.")

endmodule

bind stable_four_class_priority_queue_top sfcpq_checker u_checker (.*);

>>> tb/tb.sv
// Self-checking testbench of the stable four-class priority queue, with its own queue predictor.
`timescale 1ns / 100ps

module tb;

	localparam int QUEUE_DEPTH = sfcpq_pkg::DEPTH_DEFAULT;
	localparam logic [1:0] ACT_NOP = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [15:0] ident;
		logic [6:0]  age;
		logic        disabled;
		logic [2:0]  cls;
	} held_entry_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	sfcpq_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	sfcpq_pkg::rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [6:0] cfg_data;

	held_entry_t model_entries[$];
	logic [6:0] model_threshold = sfcpq_pkg::AGE_THRESHOLD_RESET;
	sfcpq_pkg::rsp_t pending_results[$];

	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int error_count = 0;
	int idle_cycles = 0;
	int n_requests = 0;
	int n_results = 0;
	int n_full = 0;
	int n_empty = 0;
	int n_cfg = 0;

	stable_four_class_priority_queue_top #(
		.DEPTH(QUEUE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [2:0] class_for(logic [6:0] age, logic disabled);
		logic elder;
		elder = age > model_threshold;
		if (disabled)
			return elder ? 3'd1 : 3'd2;
		return elder ? 3'd3 : 3'd4;
	endfunction

	function automatic sfcpq_pkg::rsp_t predict_queue_result(sfcpq_pkg::req_t r);
		sfcpq_pkg::rsp_t res;
		held_entry_t e;
		int pos;
		res = '0;
		case (r.action) inside
			sfcpq_pkg::ACT_INSERT: begin
				if (model_entries.size() >= QUEUE_DEPTH) begin
					res.status = sfcpq_pkg::STATUS_FULL;
				end else begin
					e.ident = r.ident;
					e.age = r.age;
					e.disabled = r.disabled;
					e.cls = class_for(r.age, r.disabled);
					pos = 0;
					while (pos < model_entries.size() && model_entries[pos].cls <= e.cls)
						pos++;
					model_entries.insert(pos, e);
				end
			end
			sfcpq_pkg::ACT_REMOVE, sfcpq_pkg::ACT_PEEK: begin
				if (model_entries.size() == 0) begin
					res.status = sfcpq_pkg::STATUS_EMPTY;
				end else begin
					res.out_ident = model_entries[0].ident;
					res.out_age = model_entries[0].age;
					res.out_disabled = model_entries[0].disabled;
					res.out_class = model_entries[0].cls;
					if (r.action == sfcpq_pkg::ACT_REMOVE)
						void'(model_entries.pop_front());
				end
			end
			default: ;
		endcase
		res.occupancy = 4'(model_entries.size());
		return res;
	endfunction

	task automatic check_field(input string label, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		sfcpq_pkg::rsp_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				model_threshold = cfg_data;
				n_cfg++;
			end
			if (req_valid && req_ready) begin
				want = predict_queue_result(req);
				if (want.status == sfcpq_pkg::STATUS_FULL)
					n_full++;
				if (want.status == sfcpq_pkg::STATUS_EMPTY)
					n_empty++;
				pending_results.push_back(want);
				n_requests++;
			end
			if (rsp_valid && rsp_ready) begin
				n_results++;
				if (pending_results.size() == 0) begin
					$display("%0t: result beat with none expected, got %0h", $time, rsp);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 16'(want.status), 16'(rsp.status));
					check_field("out_ident", want.out_ident, rsp.out_ident);
					check_field("out_age", 16'(want.out_age), 16'(rsp.out_age));
					check_field("out_disabled", 16'(want.out_disabled), 16'(rsp.out_disabled));
					check_field("out_class", 16'(want.out_class), 16'(rsp.out_class));
					check_field("occupancy", 16'(want.occupancy), 16'(rsp.occupancy));
				end
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	always @(negedge clk)
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

	function automatic sfcpq_pkg::req_t make_req(logic [1:0] action, logic [15:0] ident,
			logic [6:0] age, logic disabled);
		sfcpq_pkg::req_t r;
		r.action = action;
		r.ident = ident;
		r.age = age;
		r.disabled = disabled;
		return r;
	endfunction

	function automatic sfcpq_pkg::req_t random_request(bit filling);
		sfcpq_pkg::req_t r;
		int pick;
		int near;
		r.ident = 16'($urandom_range(65535));
		r.disabled = 1'($urandom_range(1));
		case ($urandom_range(3))
			0: begin
				near = int'(model_threshold) + int'($urandom_range(2)) - 1;
				if (near < 0)
					near = 0;
				if (near > 127)
					near = 127;
				r.age = 7'(near);
			end
			1: r.age = $urandom_range(1) ? 7'd127 : 7'd0;
			default: r.age = 7'($urandom_range(127));
		endcase
		pick = $urandom_range(99);
		if (pick < 3)
			r.action = ACT_NOP;
		else if (pick < (filling ? 68 : 28))
			r.action = sfcpq_pkg::ACT_INSERT;
		else if (pick < (filling ? 86 : 83))
			r.action = sfcpq_pkg::ACT_REMOVE;
		else
			r.action = sfcpq_pkg::ACT_PEEK;
		return r;
	endfunction

	task automatic send_req(input sfcpq_pkg::req_t item);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [6:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int send_pct, input int stall_pct,
			input logic [6:0] threshold, input int count);
		bit filling;
		wait_idle();
		write_threshold(threshold);
		send_idle_pct = send_pct;
		rsp_stall_pct = stall_pct;
		filling = 1'b1;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(19) == 0)
				filling = !filling;
			send_req(random_request(filling));
		end
	endtask

	task automatic test_empty_queue();
		send_req(make_req(sfcpq_pkg::ACT_PEEK, 16'h0000, 7'd0, 1'b0));
		send_req(make_req(sfcpq_pkg::ACT_REMOVE, 16'h0000, 7'd0, 1'b0));
		send_req(make_req(ACT_NOP, 16'h0000, 7'd0, 1'b0));
	endtask

	task automatic test_class_order();
		send_req(make_req(sfcpq_pkg::ACT_INSERT, 16'h0000, 7'd0, 1'b0));
		send_req(make_req(sfcpq_pkg::ACT_INSERT, 16'hFFFF, 7'd127, 1'b0));
		send_req(make_req(sfcpq_pkg::ACT_INSERT, 16'h1234, 7'd60, 1'b1));
		send_req(make_req(sfcpq_pkg::ACT_INSERT, 16'h5678, 7'd61, 1'b1));
		send_req(make_req(sfcpq_pkg::ACT_INSERT, 16'h0001, 7'd61, 1'b0));
		send_req(make_req(sfcpq_pkg::ACT_INSERT, 16'h8000, 7'd60, 1'b0));
		send_req(make_req(sfcpq_pkg::ACT_INSERT, 16'h00FF, 7'd127, 1'b1));
		send_req(make_req(sfcpq_pkg::ACT_INSERT, 16'hFF00, 7'd0, 1'b1));
		send_req(make_req(sfcpq_pkg::ACT_INSERT, 16'hAAAA, 7'd5, 1'b0));
		send_req(make_req(ACT_NOP, 16'hFFFF, 7'd127, 1'b1));
		send_req(make_req(sfcpq_pkg::ACT_PEEK, 16'h0000, 7'd0, 1'b0));
		repeat (QUEUE_DEPTH)
			send_req(make_req(sfcpq_pkg::ACT_REMOVE, 16'h0000, 7'd0, 1'b0));
		send_req(make_req(sfcpq_pkg::ACT_REMOVE, 16'h0000, 7'd0, 1'b0));
		send_req(make_req(sfcpq_pkg::ACT_PEEK, 16'h0000, 7'd0, 1'b0));
	endtask

	task automatic test_threshold_settings();
		run_phase(0, 0, 7'd0, 130);
		run_phase(0, 0, 7'd127, 130);
		run_phase(0, 0, 7'($urandom_range(127)), 130);
	endtask

	task automatic test_flow_control();
		run_phase(0, 0, 7'($urandom_range(127)), 170);
		run_phase(83, 0, sfcpq_pkg::AGE_THRESHOLD_RESET, 170);
		run_phase(83, 0, 7'($urandom_range(127)), 170);
		run_phase(0, 83, 7'd127, 170);
		run_phase(0, 83, 7'($urandom_range(127)), 170);
		run_phase(6, 6, 7'd0, 170);
		run_phase(6, 6, 7'($urandom_range(127)), 170);
		run_phase(0, 0, 7'($urandom_range(127)), 170);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_queue();
		test_class_order();
		test_threshold_settings();
		test_flow_control();
		wait_idle();

		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
			error_count++;
		end
		$display("Run covered %0d requests and %0d results over %0d threshold writes,",
			n_requests, n_results, n_cfg);
		$display("with %0d inserts refused on a full queue and %0d heads asked of an empty one.",
			n_full, n_empty);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sfcpq_pkg.sv
rtl/sfcpq_ctrl.sv
rtl/sfcpq_datapath.sv
rtl/stable_four_class_priority_queue_top.sv
rtl/sfcpq_checker.sv
tb/tb.sv
